FILE: src/info_frame_builder_assert.svh
// Assertion macros shared by the frame builder RTL.
// Needs a clock and an active-low reset name at each use.
`ifndef INFO_FRAME_BUILDER_ASSERT_SVH
`define INFO_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define IFB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IFB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ifb_pkg.sv
// Shared types and constants for the information frame builder.
// No dependencies.
package ifb_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDRESS = 2'd0,
        CFG_FLAG    = 2'd1,
        CFG_CTRL0   = 2'd2,
        CFG_CTRL1   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] control_seq0;
        logic [BYTE_W-1:0] control_seq1;
    } cfg_t;

    // one classified payload beat, front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] check;   // running XOR including this byte
        logic              first;
        logic              last;
        logic              seq;
    } entry_t;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_CTRL  = 3'd2,
        PH_HBCC  = 3'd3,
        PH_DATA  = 3'd4,
        PH_BCC   = 3'd5,
        PH_EFLAG = 3'd6
    } phase_t;

endpackage

FILE: src/ifb_front.sv
// Front end: accepts payload beats, tracks frame position, sequence bit
// and running check, and pushes classified entries. Depends on ifb_pkg.
module ifb_front
    import ifb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_payload_byte,
    input  logic              s_last_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output entry_t            push_entry
);

    logic              in_frame_reg, in_frame_next;
    logic              seq_reg, seq_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [BYTE_W-1:0] check_sum;
    logic              accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    assign check_sum = in_frame_reg ? (check_reg ^ s_payload_byte) : s_payload_byte;

    always_comb begin
        push_entry.data  = s_payload_byte;
        push_entry.check = check_sum;
        push_entry.first = !in_frame_reg;
        push_entry.last  = s_last_byte;
        push_entry.seq   = seq_reg;
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        seq_next      = seq_reg;
        check_next    = check_reg;
        if (accept) begin
            if (s_last_byte) begin
                in_frame_next = 1'b0;
                seq_next      = !seq_reg;
                check_next    = '0;
            end else begin
                in_frame_next = 1'b1;
                check_next    = check_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            seq_reg      <= 1'b0;
            check_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            seq_reg      <= seq_next;
            check_reg    <= check_next;
        end
    end

endmodule

FILE: src/ifb_queue.sv
// Two-entry queue between front and back ends.
// Depends on ifb_pkg for the entry type.
module ifb_queue
    import ifb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_entry,
    output logic   rd_valid,
    input  logic   rd_pop,
    output entry_t rd_entry
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign do_push  = wr_valid && wr_ready;
    assign do_pop   = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/ifb_back.sv
// Back end: walks the head entry through header (if first), data and trailer
// (if last) phases into the output register. Depends on ifb_pkg and the assertion macros.
`include "info_frame_builder_assert.svh"

module ifb_back
    import ifb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              head_valid,
    input  entry_t            head,
    output logic              head_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_last_of_run,
    output logic              m_end_of_frame
);

    phase_t            phase_reg, phase_next, cur_phase;
    logic              emit, run_done;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              last_reg;
    logic              eof_reg, eof_next;
    logic [BYTE_W-1:0] ctrl;

    assign emit = head_valid && (!m_valid_reg || m_ready);
    assign ctrl = head.seq ? cfg.control_seq1 : cfg.control_seq0;

    // a continuation entry skips the header
    assign cur_phase = (phase_reg == PH_FLAG && !head.first) ? PH_DATA : phase_reg;

    // next state
    always_comb begin
        phase_next = phase_reg;
        run_done   = 1'b0;
        unique case (cur_phase)
            PH_FLAG:  phase_next = PH_ADDR;
            PH_ADDR:  phase_next = PH_CTRL;
            PH_CTRL:  phase_next = PH_HBCC;
            PH_HBCC:  phase_next = PH_DATA;
            PH_DATA: begin
                if (head.last) begin
                    phase_next = PH_BCC;
                end else begin
                    run_done   = 1'b1;
                    phase_next = PH_FLAG;
                end
            end
            PH_BCC:   phase_next = PH_EFLAG;
            PH_EFLAG: begin
                run_done   = 1'b1;
                phase_next = PH_FLAG;
            end
            default: begin
                run_done   = 1'b1;
                phase_next = PH_FLAG;
            end
        endcase
        if (!emit) begin
            phase_next = phase_reg;
        end
    end

    assign head_pop = emit && run_done;

    // outputs
    always_comb begin
        eof_next = 1'b0;
        unique case (cur_phase)
            PH_FLAG:  out_byte_next = cfg.flag_byte;
            PH_ADDR:  out_byte_next = cfg.address_byte;
            PH_CTRL:  out_byte_next = ctrl;
            PH_HBCC:  out_byte_next = cfg.address_byte ^ ctrl;
            PH_DATA:  out_byte_next = head.data;
            PH_BCC:   out_byte_next = head.check;
            PH_EFLAG: begin
                out_byte_next = cfg.flag_byte;
                eof_next      = 1'b1;
            end
            default:  out_byte_next = head.data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg <= out_byte_next;
            last_reg     <= run_done;
            eof_reg      <= eof_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FLAG;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_last_of_run  = last_reg;
    assign m_end_of_frame = eof_reg;

    `IFB_ASSERT_IMP(a_mid_entry_head, aclk, aresetn, phase_reg != PH_FLAG, head_valid, "phase advanced without a head entry")
    `IFB_ASSERT_IMP(a_header_first, aclk, aresetn, phase_reg == PH_ADDR || phase_reg == PH_CTRL || phase_reg == PH_HBCC, head.first, "header phase on a continuation entry")
    `IFB_ASSERT_IMP(a_eof_last, aclk, aresetn, m_valid_reg && eof_reg, last_reg, "closing flag not marked last of run")
    `IFB_ASSERT_NXT(a_pop_rewinds, aclk, aresetn, head_pop, phase_reg == PH_FLAG, "phase not rewound after pop")

endmodule

FILE: src/info_frame_builder.sv
// Top level of the information frame builder: configuration registers,
// front end, queue and back end. Depends on ifb_pkg and the ifb_* modules.
//
//  port group   dir  handshake          beat contents
//  s_*          in   s_valid/s_ready    payload byte, last-byte mark
//  m_*          out  m_valid/m_ready    framed byte, last of run, end of frame
//  cfg_*        in   cfg_wr_en          register index, write data
//
// Unless the output stalls, mid-packet bytes flow at one beat per cycle; a first
// byte adds four header beats and a last byte two trailer beats, one output beat
// per cycle. A beat passes the queue and then the output register to m_*.
// Reset is synchronous, active low; it restores register defaults.
// A two-entry queue lets input beats land while the output stalls.
module info_frame_builder
    import ifb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_payload_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic                 m_last_of_run,
    output logic                 m_end_of_frame
);

    cfg_t   cfg_reg;
    logic   push_valid, push_ready;
    entry_t push_entry;
    logic   head_valid, head_pop;
    entry_t head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.address_byte <= 8'd3;
            cfg_reg.flag_byte    <= 8'd126;
            cfg_reg.control_seq0 <= 8'd0;
            cfg_reg.control_seq1 <= 8'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ADDRESS: cfg_reg.address_byte <= cfg_wdata;
                CFG_FLAG:    cfg_reg.flag_byte    <= cfg_wdata;
                CFG_CTRL0:   cfg_reg.control_seq0 <= cfg_wdata;
                CFG_CTRL1:   cfg_reg.control_seq1 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ifb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    ifb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_entry (head)
    );

    ifb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .head_valid     (head_valid),
        .head           (head),
        .head_pop       (head_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule

FILE: dv/tb.sv
// Testbench for info_frame_builder: a queue-fed driver, a frame predictor and a
// monitor that checks every output beat field by field. Depends on ifb_pkg.
`timescale 1ns / 100ps

module tb;
    import ifb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic              last;
    } pay_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              end_of_frame;
    } frame_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_payload_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_last_of_run;
    logic                 m_end_of_frame;

    pay_beat_t   pending_q[$];
    frame_beat_t frame_q[$];

    // shadow of the block's registers and framing state
    cfg_t              regs;
    logic              seq_bit;
    logic              frame_open;
    logic [BYTE_W-1:0] bcc;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sink_hold_left = 0;
    int unsigned errors = 0;

    info_frame_builder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_frame (m_end_of_frame)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic push_frame_beat(input logic [BYTE_W-1:0] b, input logic eof);
        frame_beat_t fb;
        fb.out_byte     = b;
        fb.last_of_run  = 1'b0;
        fb.end_of_frame = eof;
        frame_q.push_back(fb);
    endtask

    // expected output beats for one accepted payload beat
    task automatic frame_payload(input logic [BYTE_W-1:0] data, input logic last);
        logic [BYTE_W-1:0] ctrl;
        frame_beat_t       tail;
        if (!frame_open) begin
            ctrl = seq_bit ? regs.control_seq1 : regs.control_seq0;
            push_frame_beat(regs.flag_byte, 1'b0);
            push_frame_beat(regs.address_byte, 1'b0);
            push_frame_beat(ctrl, 1'b0);
            push_frame_beat(regs.address_byte ^ ctrl, 1'b0);
            bcc        = data;
            frame_open = 1'b1;
        end else begin
            bcc = bcc ^ data;
        end
        push_frame_beat(data, 1'b0);
        if (last) begin
            push_frame_beat(bcc, 1'b0);
            push_frame_beat(regs.flag_byte, 1'b1);
            seq_bit    = ~seq_bit;
            frame_open = 1'b0;
            bcc        = '0;
        end
        tail = frame_q.pop_back();
        tail.last_of_run = 1'b1;
        frame_q.push_back(tail);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                frame_payload(s_payload_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid        <= 1'b1;
                    s_payload_byte <= pending_q[0].payload;
                    s_last_byte    <= pending_q[0].last;
                    void'(pending_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge aclk) begin
        if (sink_hold_left != 0)
            sink_hold_left <= sink_hold_left - 1;
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    $error("unexpected beat: out_byte %0h", m_out_byte);
                    errors++;
                end else begin
                    if (m_out_byte !== frame_q[0].out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               frame_q[0].out_byte, m_out_byte);
                        errors++;
                    end
                    if (m_last_of_run !== frame_q[0].last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               frame_q[0].last_of_run, m_last_of_run);
                        errors++;
                    end
                    if (m_end_of_frame !== frame_q[0].end_of_frame) begin
                        $error("end_of_frame: expected %0b, got %0b",
                               frame_q[0].end_of_frame, m_end_of_frame);
                        errors++;
                    end
                    void'(frame_q.pop_front());
                end
            end
            m_ready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic cfg_write(input cfg_idx_t idx, input logic [BYTE_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ADDRESS: regs.address_byte = val;
            CFG_FLAG:    regs.flag_byte    = val;
            CFG_CTRL0:   regs.control_seq0 = val;
            CFG_CTRL1:   regs.control_seq1 = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] flag,
                            input logic [BYTE_W-1:0] c0, input logic [BYTE_W-1:0] c1);
        cfg_write(CFG_ADDRESS, addr);
        cfg_write(CFG_FLAG, flag);
        cfg_write(CFG_CTRL0, c0);
        cfg_write(CFG_CTRL1, c1);
    endtask

    task automatic queue_beat(input logic [BYTE_W-1:0] b, input logic last);
        pay_beat_t pb;
        pb.payload = b;
        pb.last    = last;
        pending_q.push_back(pb);
    endtask

    // random packets until about n beats are queued; mostly short ones
    task automatic queue_packets(input int n);
        int len;
        int queued;
        queued = 0;
        while (queued < n) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(5, 1);
            for (int i = 0; i < len; i++)
                queue_beat(BYTE_W'($urandom_range(255)), i == len - 1);
            queued += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_valid || frame_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        regs.address_byte = 8'd3;
        regs.flag_byte    = 8'd126;
        regs.control_seq0 = 8'd0;
        regs.control_seq1 = 8'd64;
        seq_bit    = 1'b0;
        frame_open = 1'b0;
        bcc        = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset defaults, single- and multi-byte frames on both sequence values
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'h55, 1'b0);
        queue_beat(8'hAA, 1'b1);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h81, 1'b1);
        queue_beat(8'h01, 1'b1);
        wait_drained();

        set_regs(8'h00, 8'h00, 8'h00, 8'h00);
        queue_beat(8'h80, 1'b1);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'h7E, 1'b1);
        wait_drained();

        set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_beat(8'h00, 1'b1);
        queue_beat(8'h7F, 1'b0);
        queue_beat(8'hFE, 1'b1);
        queue_beat(8'h3C, 1'b1);
        wait_drained();

        // random phases with different idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            set_regs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                     BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
            queue_packets(15);
            wait_drained();
        end

        // back-pressure: receiver holds off while the sender keeps offering
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_regs(8'h03, 8'h7E, 8'h00, 8'h40);
        @(posedge aclk);
        sink_hold_left <= 300;
        queue_packets(12);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (errors == 0 && frame_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
